// ===== rtl/tfna_pkg.sv =====
// tfna_pkg: widths, constants and shared types of the triangle facet normal/area core
// no dependencies

package tfna_pkg;

  localparam int CW        = 16;           // coordinate and field width
  localparam int EW        = CW + 1;       // edge width, signed
  localparam int SW        = CW + 2;       // vertex sum width, signed
  localparam int PW        = 2 * EW;       // edge product width, signed
  localparam int XW        = PW + 1;       // cross component width, signed
  localparam int MW        = PW;           // cross component magnitude width
  localparam int HW        = MW / 2;       // half of the magnitude for split squaring
  localparam int SQCW      = 2 * MW;       // one squared component
  localparam int SQW       = SQCW + 2;     // sum of three squares
  localparam int LW        = SQW / 2;      // root width
  localparam int SQ_STEPS  = LW;           // one root bit per stage
  localparam int RW        = LW + 3;       // root remainder width
  localparam int FB        = 14;           // normal fraction bits
  localparam int DIV_STEPS = FB + 2;       // quotient bits, incl. rounding bit
  localparam int DRW       = LW + 1;       // divider remainder width
  localparam int AW        = 34;           // area field width
  localparam int RECIP_SH  = SW - 1;       // reciprocal shift for divide by three
  localparam logic [CW-1:0] RECIP3 = CW'(((1 << RECIP_SH) + 2) / 3);

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [2:0][CW-1:0] cent;
    logic [CW-1:0]      weight;
  } tfna_side_t;

endpackage

// ===== rtl/triangle_facet_normal_area_core.sv =====
// triangle_facet_normal_area_core: top level, unit normal, area and centroid of a triangle
// depends on tfna_pkg, tfna_front, tfna_sqrt, tfna_div
//
//   channel | handshake                | payload
//   --------+--------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o  | ax..cz_i, facet_weight_i
//   out     | out_valid_o / out_ready_i| normal_*_o, area_o, centroid_*_o,
//           |                          | degenerate_o, weight_out_o
//
// one request per cycle while the output register is not stalled; front, root, divide and output stages in that order
// the 35-stage root pipeline, one root bit per stage, sets most of the latency
// reset clears only the stage valid bits; payload registers carry no reset
// the whole pipeline holds while the output register is full and not taken,
// so a stall loses and repeats nothing

module triangle_facet_normal_area_core import tfna_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CW-1:0]        ax_i,
  input  logic [CW-1:0]        ay_i,
  input  logic [CW-1:0]        az_i,
  input  logic [CW-1:0]        bx_i,
  input  logic [CW-1:0]        by_i,
  input  logic [CW-1:0]        bz_i,
  input  logic [CW-1:0]        cx_i,
  input  logic [CW-1:0]        cy_i,
  input  logic [CW-1:0]        cz_i,
  input  logic [CW-1:0]        facet_weight_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [CW-1:0] normal_x_o,
  output logic signed [CW-1:0] normal_y_o,
  output logic signed [CW-1:0] normal_z_o,
  output logic [AW-1:0]        area_o,
  output logic signed [CW-1:0] centroid_x_o,
  output logic signed [CW-1:0] centroid_y_o,
  output logic signed [CW-1:0] centroid_z_o,
  output logic                 degenerate_o,
  output logic [CW-1:0]        weight_out_o
);

  // global advance: move unless a finished result sits unclaimed
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic           fr_valid;
  logic [SQW-1:0] fr_sq;
  tfna_side_t     fr_side;

  logic           sq_valid;
  logic [LW-1:0]  sq_len;
  tfna_side_t     sq_side;

  logic [2:0][CW-1:0] normal, cent;

  // edges, cross product, centroid, sum of squares
  tfna_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .a_i      ({az_i, ay_i, ax_i}),
    .b_i      ({bz_i, by_i, bx_i}),
    .c_i      ({cz_i, cy_i, cx_i}),
    .weight_i (facet_weight_i),
    .valid_o  (fr_valid),
    .sq_o     (fr_sq),
    .side_o   (fr_side)
  );

  // length of the cross product
  tfna_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (fr_valid),
    .sq_i     (fr_sq),
    .side_i   (fr_side),
    .valid_o  (sq_valid),
    .len_o    (sq_len),
    .side_o   (sq_side)
  );

  // normalize, round, clamp, register the result
  tfna_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (sq_valid),
    .len_i        (sq_len),
    .side_i       (sq_side),
    .valid_o      (out_valid_o),
    .normal_o     (normal),
    .area_o       (area_o),
    .cent_o       (cent),
    .degenerate_o (degenerate_o),
    .weight_o     (weight_out_o)
  );

  assign normal_x_o   = normal[0];
  assign normal_y_o   = normal[1];
  assign normal_z_o   = normal[2];
  assign centroid_x_o = cent[0];
  assign centroid_y_o = cent[1];
  assign centroid_z_o = cent[2];

endmodule

// ===== rtl/tfna_front.sv =====
// tfna_front: edges, cross product, centroid and sum of squared cross components
// depends on tfna_pkg

module tfna_front import tfna_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][CW-1:0]  a_i,
  input  logic [2:0][CW-1:0]  b_i,
  input  logic [2:0][CW-1:0]  c_i,
  input  logic [CW-1:0]       weight_i,
  output logic                valid_o,
  output logic [SQW-1:0]      sq_o,
  output tfna_side_t          side_o
);

  logic [5:0] v_q;

  // stage 1
  logic [2:0][EW-1:0] e1_d, e1_q, e2_d, e2_q;
  logic [2:0][SW-1:0] s_d, s_q;
  logic [CW-1:0]      w1_q;
  // stage 2
  logic [5:0][PW-1:0] p_d, p_q;
  logic [2:0][CW+EW-1:0] cp_d, cp_q;
  logic [2:0]         cn_q;
  logic [CW-1:0]      w2_q;
  // stage 3
  tfna_side_t         s3_d, s3_q;
  // stage 4
  logic [2:0][MW-1:0] hh_d, hh_q, hl_d, hl_q, ll_d, ll_q;
  tfna_side_t         s4_q;
  // stage 5
  logic [2:0][SQCW-1:0] sc_d, sc_q;
  tfna_side_t         s5_q;
  // stage 6
  logic [SQW-1:0]     sq_d, sq_q;
  tfna_side_t         s6_q;

  logic [2:0][EW-1:0] sabs;
  logic [2:0][XW-1:0] x;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = {b_i[k][CW-1], b_i[k]} - {a_i[k][CW-1], a_i[k]};
      e2_d[k] = {c_i[k][CW-1], c_i[k]} - {a_i[k][CW-1], a_i[k]};
      s_d[k]  = {{2{a_i[k][CW-1]}}, a_i[k]} + {{2{b_i[k][CW-1]}}, b_i[k]}
              + {{2{c_i[k][CW-1]}}, c_i[k]};
    end
  end

  always_comb begin
    p_d[0] = PW'($signed(e1_q[1]) * $signed(e2_q[2]));
    p_d[1] = PW'($signed(e1_q[2]) * $signed(e2_q[1]));
    p_d[2] = PW'($signed(e1_q[2]) * $signed(e2_q[0]));
    p_d[3] = PW'($signed(e1_q[0]) * $signed(e2_q[2]));
    p_d[4] = PW'($signed(e1_q[0]) * $signed(e2_q[1]));
    p_d[5] = PW'($signed(e1_q[1]) * $signed(e2_q[0]));
    for (int k = 0; k < 3; k++) begin
      sabs[k] = s_q[k][SW-1] ? EW'(-s_q[k]) : EW'(s_q[k]);
      cp_d[k] = (CW+EW)'(sabs[k] * RECIP3);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x[k] = {p_q[2*k][PW-1], p_q[2*k]} - {p_q[2*k+1][PW-1], p_q[2*k+1]};
      s3_d.neg[k] = x[k][XW-1];
      s3_d.mag[k] = x[k][XW-1] ? MW'(-x[k]) : MW'(x[k]);
      s3_d.cent[k] = cn_q[k] ? CW'(-cp_q[k][CW+EW-1:RECIP_SH])
                             : CW'(cp_q[k][CW+EW-1:RECIP_SH]);
    end
    s3_d.weight = w2_q;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_d[k] = MW'(s3_q.mag[k][MW-1:HW] * s3_q.mag[k][MW-1:HW]);
      hl_d[k] = MW'(s3_q.mag[k][MW-1:HW] * s3_q.mag[k][HW-1:0]);
      ll_d[k] = MW'(s3_q.mag[k][HW-1:0] * s3_q.mag[k][HW-1:0]);
      sc_d[k] = {hh_q[k], {MW{1'b0}}} + {{(HW-1){1'b0}}, hl_q[k], {(HW+1){1'b0}}}
              + {{MW{1'b0}}, ll_q[k]};
    end
    sq_d = {2'b00, sc_q[0]} + {2'b00, sc_q[1]} + {2'b00, sc_q[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      s_q  <= s_d;
      w1_q <= weight_i;
      p_q  <= p_d;
      cp_q <= cp_d;
      for (int k = 0; k < 3; k++) cn_q[k] <= s_q[k][SW-1];
      w2_q <= w1_q;
      s3_q <= s3_d;
      hh_q <= hh_d;
      hl_q <= hl_d;
      ll_q <= ll_d;
      s4_q <= s3_q;
      sc_q <= sc_d;
      s5_q <= s4_q;
      sq_q <= sq_d;
      s6_q <= s5_q;
    end
  end

  assign valid_o = v_q[5];
  assign sq_o    = sq_q;
  assign side_o  = s6_q;

endmodule

// ===== rtl/tfna_sqrt.sv =====
// tfna_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on tfna_pkg

module tfna_sqrt import tfna_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [SQW-1:0] sq_i,
  input  tfna_side_t     side_i,
  output logic           valid_o,
  output logic [LW-1:0]  len_o,
  output tfna_side_t     side_o
);

  logic [SQ_STEPS-1:0]          v_q;
  logic [SQ_STEPS-1:0][SQW-1:0] n_q;
  logic [SQ_STEPS-1:0][RW-1:0]  r_q;
  logic [SQ_STEPS-1:0][LW-1:0]  q_q;
  tfna_side_t                   s_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SQW-1:0] n_src;
    logic [RW-1:0]  r_src, r_sh, trial, r_d;
    logic [LW-1:0]  q_src, q_d;
    tfna_side_t     s_src;
    logic           v_src;

    if (k == 0) begin : g_first
      assign n_src = sq_i;
      assign r_src = '0;
      assign q_src = '0;
      assign s_src = side_i;
      assign v_src = valid_i;
    end else begin : g_next
      assign n_src = n_q[k-1];
      assign r_src = r_q[k-1];
      assign q_src = q_q[k-1];
      assign s_src = s_q[k-1];
      assign v_src = v_q[k-1];
    end

    always_comb begin
      r_sh  = {r_src[RW-3:0], n_src[SQW-1-2*k -: 2]};
      trial = {1'b0, q_src, 2'b01};
      if (r_sh >= trial) begin
        r_d = r_sh - trial;
        q_d = {q_src[LW-2:0], 1'b1};
      end else begin
        r_d = r_sh;
        q_d = {q_src[LW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_src;
        r_q[k] <= r_d;
        q_q[k] <= q_d;
        s_q[k] <= s_src;
      end
    end
  end

  assign valid_o = v_q[SQ_STEPS-1];
  assign len_o   = q_q[SQ_STEPS-1];
  assign side_o  = s_q[SQ_STEPS-1];

endmodule

// ===== rtl/tfna_div.sv =====
// tfna_div: pipelined restoring division of the cross magnitudes by the length,
// rounding, clamping and output register; depends on tfna_pkg

module tfna_div import tfna_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [LW-1:0]      len_i,
  input  tfna_side_t         side_i,
  output logic               valid_o,
  output logic [2:0][CW-1:0] normal_o,
  output logic [AW-1:0]      area_o,
  output logic [2:0][CW-1:0] cent_o,
  output logic               degenerate_o,
  output logic [CW-1:0]      weight_o
);

  logic [DIV_STEPS-1:0]                   v_q;
  logic [DIV_STEPS-1:0][LW-1:0]           l_q;
  logic [DIV_STEPS-1:0][2:0][DRW-1:0]     r_q;
  logic [DIV_STEPS-1:0][2:0][DIV_STEPS-1:0] q_q;
  tfna_side_t                             s_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [LW-1:0]                len_src;
    logic [2:0][DRW-1:0]          r_src, r_sh, r_d;
    logic [2:0][DIV_STEPS-1:0]    q_src, q_d;
    tfna_side_t                   s_src;
    logic                         v_src;
    logic [2:0]                   bit_in;

    if (k == 0) begin : g_first
      assign len_src = len_i;
      assign s_src   = side_i;
      assign v_src   = valid_i;
      assign q_src   = '0;
      for (genvar c = 0; c < 3; c++) begin : g_c
        // the magnitude never exceeds the length, so half of it starts the remainder
        assign r_src[c]  = DRW'(side_i.mag[c][MW-1:1]);
        assign bit_in[c] = side_i.mag[c][0];
      end
    end else begin : g_next
      assign len_src = l_q[k-1];
      assign s_src   = s_q[k-1];
      assign v_src   = v_q[k-1];
      assign q_src   = q_q[k-1];
      assign r_src   = r_q[k-1];
      assign bit_in  = '0;
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        r_sh[c] = {r_src[c][DRW-2:0], bit_in[c]};
        if (r_sh[c] >= {1'b0, len_src}) begin
          r_d[c] = r_sh[c] - {1'b0, len_src};
          q_d[c] = {q_src[c][DIV_STEPS-2:0], 1'b1};
        end else begin
          r_d[c] = r_sh[c];
          q_d[c] = {q_src[c][DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        l_q[k] <= len_src;
        r_q[k] <= r_d;
        q_q[k] <= q_d;
        s_q[k] <= s_src;
      end
    end
  end

  // rounding, clamping, sign and output register
  localparam logic [DIV_STEPS-1:0] Lim = DIV_STEPS'(1) << FB;

  logic [2:0][CW-1:0]      normal_d, normal_q;
  logic [2:0][DIV_STEPS-1:0] qr;
  logic [DIV_STEPS:0]      qinc [3];
  logic                    deg_d, deg_q, v_out_q;
  logic [AW-1:0]           area_q;
  tfna_side_t              s_out_q;
  logic [LW-1:0]           len_f;

  assign len_f = l_q[DIV_STEPS-1];
  assign deg_d = (len_f == '0);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qinc[c] = {1'b0, q_q[DIV_STEPS-1][c]} + (DIV_STEPS+1)'(1);
      qr[c]   = qinc[c][DIV_STEPS:1];
      if (qr[c] > Lim) qr[c] = Lim;
      if (deg_d) begin
        normal_d[c] = '0;
      end else if (s_q[DIV_STEPS-1].neg[c]) begin
        normal_d[c] = CW'(-qr[c]);
      end else begin
        normal_d[c] = CW'(qr[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_out_q <= v_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      normal_q <= normal_d;
      area_q   <= AW'(len_f[LW-1:1]);
      deg_q    <= deg_d;
      s_out_q  <= s_q[DIV_STEPS-1];
    end
  end

  assign valid_o      = v_out_q;
  assign normal_o     = normal_q;
  assign area_o       = area_q;
  assign cent_o       = s_out_q.cent;
  assign degenerate_o = deg_q;
  assign weight_o     = s_out_q.weight;

endmodule

// ===== bench/tfna_checker.sv =====
// tfna_checker: watches both channels of the facet core, predicts each result, compares
// depends on tfna_pkg for field widths

module tfna_checker import tfna_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [CW-1:0]        ax_i,
  input  logic [CW-1:0]        ay_i,
  input  logic [CW-1:0]        az_i,
  input  logic [CW-1:0]        bx_i,
  input  logic [CW-1:0]        by_i,
  input  logic [CW-1:0]        bz_i,
  input  logic [CW-1:0]        cx_i,
  input  logic [CW-1:0]        cy_i,
  input  logic [CW-1:0]        cz_i,
  input  logic [CW-1:0]        facet_weight_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [CW-1:0] normal_x_i,
  input  logic signed [CW-1:0] normal_y_i,
  input  logic signed [CW-1:0] normal_z_i,
  input  logic [AW-1:0]        area_i,
  input  logic signed [CW-1:0] centroid_x_i,
  input  logic signed [CW-1:0] centroid_y_i,
  input  logic signed [CW-1:0] centroid_z_i,
  input  logic                 degenerate_i,
  input  logic [CW-1:0]        weight_out_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   facets_o,
  output int                   degen_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0][CW-1:0] nrm;
    logic [AW-1:0]      area;
    logic [2:0][CW-1:0] cent;
    logic               degen;
    logic [CW-1:0]      weight;
  } facet_res_t;

  facet_res_t facet_fifo[$];

  // integer square root, floor
  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // |c| * 2^FB / len, nearest with halves away from zero, clamped
  function automatic logic [CW-1:0] unit_comp(longint c, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    q = ((mag << (FB + 1)) / len + 64'd1) >> 1;
    if (q > (64'd1 << FB)) q = 64'd1 << FB;
    return (c < 0) ? CW'(-longint'(q)) : CW'(q);
  endfunction

  function automatic facet_res_t facet_predict(logic [2:0][CW-1:0] va, logic [2:0][CW-1:0] vb,
                                               logic [2:0][CW-1:0] vc, logic [CW-1:0] w);
    facet_res_t   r;
    longint       a[3], b[3], c[3], e1[3], e2[3], x[3];
    logic [127:0] sq;
    logic [63:0]  len;
    logic [63:0]  m;
    for (int i = 0; i < 3; i++) begin
      a[i]  = longint'($signed(va[i]));
      b[i]  = longint'($signed(vb[i]));
      c[i]  = longint'($signed(vc[i]));
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    x[0] = e1[1] * e2[2] - e1[2] * e2[1];
    x[1] = e1[2] * e2[0] - e1[0] * e2[2];
    x[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      m  = (x[i] < 0) ? 64'(-x[i]) : 64'(x[i]);
      sq = sq + {64'd0, m} * {64'd0, m};
    end
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      r.nrm[i]  = (len == 0) ? '0 : unit_comp(x[i], len);
      r.cent[i] = CW'((a[i] + b[i] + c[i]) / 3);
    end
    r.area   = AW'(len >> 1);
    r.degen  = (len == 0);
    r.weight = w;
    return r;
  endfunction

  task automatic cmp_field(string nm, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      errors_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, nm, exp_v, got_v);
    end
  endtask

  initial begin
    errors_o = 0;
    facets_o = 0;
    degen_seen_o = 0;
  end

  assign pending_o = facet_fifo.size();

  always @(posedge clk_i) begin
    facet_res_t e;
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (facet_fifo.size() == 0) begin
        errors_o++;
        $display("%0t ns: result with nothing expected", $realtime);
      end else begin
        e = facet_fifo.pop_front();
        cmp_field("normal_x",   $signed(e.nrm[0]),  normal_x_i);
        cmp_field("normal_y",   $signed(e.nrm[1]),  normal_y_i);
        cmp_field("normal_z",   $signed(e.nrm[2]),  normal_z_i);
        cmp_field("area",       e.area,             area_i);
        cmp_field("centroid_x", $signed(e.cent[0]), centroid_x_i);
        cmp_field("centroid_y", $signed(e.cent[1]), centroid_y_i);
        cmp_field("centroid_z", $signed(e.cent[2]), centroid_z_i);
        cmp_field("degenerate", e.degen,            degenerate_i);
        cmp_field("weight_out", e.weight,           weight_out_i);
        facets_o++;
        if (e.degen) degen_seen_o++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_i)
      facet_fifo.push_back(facet_predict({az_i, ay_i, ax_i}, {bz_i, by_i, bx_i},
                                         {cz_i, cy_i, cx_i}, facet_weight_i));
  end

endmodule

// ===== bench/tb_triangle_facet_normal_area_core.sv =====
// tb_triangle_facet_normal_area_core: stimulus and verdict for the facet core
// depends on tfna_pkg, triangle_facet_normal_area_core and tfna_checker

module tb_triangle_facet_normal_area_core;
  import tfna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int N_RANDOM    = 800;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the pipeline

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CW-1:0]        ax_i = '0, ay_i = '0, az_i = '0;
  logic [CW-1:0]        bx_i = '0, by_i = '0, bz_i = '0;
  logic [CW-1:0]        cx_i = '0, cy_i = '0, cz_i = '0;
  logic [CW-1:0]        facet_weight_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [CW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [AW-1:0]        area_o;
  logic signed [CW-1:0] centroid_x_o, centroid_y_o, centroid_z_o;
  logic                 degenerate_o;
  logic [CW-1:0]        weight_out_o;

  int errors, pending, facets, degen_seen;
  int cycles = 0;
  int send_idle_pct = 0;   // chance in 100 that the sender sits out a cycle
  int recv_stall_pct = 0;  // chance in 100 that the receiver drops ready
  bit hold_go = 1'b0;      // main flow asks once for the long hold-off
  bit hold_started = 1'b0;
  int hold_left = 0;

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  triangle_facet_normal_area_core uut (.*);

  tfna_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i, .facet_weight_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .normal_x_i(normal_x_o), .normal_y_i(normal_y_o), .normal_z_i(normal_z_o),
    .area_i(area_o), .centroid_x_i(centroid_x_o), .centroid_y_i(centroid_y_o),
    .centroid_z_i(centroid_z_o), .degenerate_i(degenerate_o), .weight_out_i(weight_out_o),
    .errors_o(errors), .pending_o(pending), .facets_o(facets), .degen_seen_o(degen_seen)
  );

  // watchdog, ends a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** triangle_facet_normal_area_core: FAILED **");
      $finish;
    end
  end

  // receiver side: random stalls, plus one long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one triangle at the falling edge, hold it until the request is taken
  task automatic send_facet(logic [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ax_i <= a0; ay_i <= a1; az_i <= a2;
    bx_i <= b0; by_i <= b1; bz_i <= b2;
    cx_i <= c0; cy_i <= c1; cz_i <= c2;
    facet_weight_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // random triangle: full range, small local triangles, or collinear/coincident ones
  task automatic send_random();
    logic [CW-1:0] v[9];
    int            kind;
    int            sp;
    kind = $urandom_range(9);
    foreach (v[i]) v[i] = CW'($urandom);
    if (kind >= 4 && kind <= 7) begin
      // small triangle near the first vertex
      sp = (kind == 7) ? 4 : 300;
      for (int i = 3; i < 9; i++)
        v[i] = v[i % 3] + CW'($urandom_range(2 * sp) - sp);
    end else if (kind == 8) begin
      // third vertex on the line through the first two
      for (int i = 0; i < 3; i++) begin
        v[3 + i] = v[i] + CW'($urandom_range(200) - 100);
        v[6 + i] = v[i] + ((v[3 + i] - v[i]) << 1);
      end
    end else if (kind == 9) begin
      // two vertices coincide
      sp = $urandom_range(2);
      for (int i = 0; i < 3; i++) v[3 * ((sp + 1) % 3) + i] = v[3 * sp + i];
    end
    send_facet(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], CW'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners
    send_facet(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000);                  // all zero, degenerate
    send_facet(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0, 16'hFFFF);    // unit right triangle
    send_facet(0, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 16'h0100);    // normal along x
    send_facet(0, 0, 0, 0, 0, 16'h0100, 16'h0100, 0, 0, 16'h1234);    // normal along y
    send_facet(0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0, 16'h8000);    // normal along -z
    send_facet(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
               16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);                // largest edges
    send_facet(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
               16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001);                // large, all components
    send_facet(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h00FF);                // all max, degenerate
    send_facet(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 16'h8000, 16'h8000, 16'hFF00);                // all min, degenerate
    send_facet(0, 0, 0, 1, 1, 1, 2, 2, 2, 16'h0001);                   // collinear
    send_facet(16'hFFFF, 16'hFFFE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0);     // centroid sums -1, -2
    send_facet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF,
               16'hFFFE, 16'hFFFF, 16'hFFFF, 0);                       // tiny, negative sums
    send_facet(0, 0, 0, 1, 0, 0, 0, 1, 0, 16'h5555);                   // smallest area
    send_facet(0, 0, 0, 1, 0, 0, 1, 1, 1, 16'hAAAA);                   // off-axis normal
    send_facet(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
               16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);                // mixed extremes

    // random part in idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 37 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 37 : 0;
      for (int k = 0; k < N_RANDOM / 5; k++) send_random();
    end

    // pressure: receiver holds off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    for (int k = 0; k < N_RANDOM / 5; k++) send_random();
    in_valid_i <= 1'b0;

    // drain, then allow the pipeline latency to pass
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("covered %0d facets (%0d degenerate) over idle, stall and back-pressure phases",
             facets, degen_seen);
    if (errors == 0 && pending == 0) begin
      $display("** triangle_facet_normal_area_core: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** triangle_facet_normal_area_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== triangle_facet_normal_area_core.f =====
rtl/tfna_pkg.sv
rtl/tfna_front.sv
rtl/tfna_sqrt.sv
rtl/tfna_div.sv
rtl/triangle_facet_normal_area_core.sv
bench/tfna_checker.sv
bench/tb_triangle_facet_normal_area_core.sv
